// ===== rtl/sha256_pkg.sv =====
// ============================================================================
// SHA-256 package
// Round constants, initial hash values and the SHA-256 helper functions.
// ============================================================================
package sha256_pkg;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int         LEN_POS  = 56;

    // Eight working variables a..h.
    typedef logic [31:0] word_t;
    typedef word_t       state_t [8];

    function automatic word_t ror(input word_t v, input int n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

// ===== rtl/sha256_ram.sv =====
// ============================================================================
// SHA-256 generic RAM
// Single write port, single read port, registered read data.
// ============================================================================
module sha256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/sha256_core.sv =====
// ============================================================================
// SHA-256 compression core
// Runs 64 rounds, one per cycle. The 16 loaded block words live in a 16-word
// RAM read in rounds 0..15; later schedule words come from a register shift window.
// ============================================================================
module sha256_core
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Block word loading: 16 words before start.
    input  logic        ld_en,
    input  logic [3:0]  ld_addr,
    input  logic [31:0] ld_data,
    input  logic        start,
    input  logic        reinit,
    output logic        busy,
    input  logic [2:0]  hash_sel,
    output logic [31:0] hash_word
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_ADD   = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    state_t      v_reg, v_next;
    state_t      h_reg, h_next;
    // Shift window of the last 16 schedule words (w[t-16] .. w[t-1]).
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic        wr_en;
    logic [3:0]  wr_addr, rd_addr;
    logic [31:0] wr_data, rd_data, w_t, t1, t2;

    sha256_ram #(.WIDTH(32), .DEPTH(16)) u_wram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign hash_word = h_reg[hash_sel];

    // Control FSM, round datapath and final hash addition. Rounds below 16 take the loaded word from the RAM.
    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        v_next     = v_reg;
        h_next     = h_reg;
        win_next   = win_reg;
        wr_en      = ld_en;
        wr_addr    = ld_addr;
        wr_data    = ld_data;
        rd_addr    = 4'd0;
        w_t        = '0;
        t1         = '0;
        t2         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (reinit) begin
                    h_next = INIT_H;
                end
                if (start) begin
                    state_next = ST_FETCH;
                    round_next = '0;
                    v_next     = h_reg;
                end
            end
            ST_FETCH: begin
                rd_addr    = 4'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                rd_addr = round_reg[3:0] + 4'd1;
                if (round_reg < 6'd16) begin
                    w_t = rd_data;
                end else begin
                    w_t = win_reg[0] + sig0(win_reg[1]) + win_reg[9] + sig1(win_reg[14]);
                end
                for (int i = 0; i < 15; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[15] = w_t;
                t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
                     + ROUND_K[round_reg] + w_t;
                t2 = bsig0(v_reg[0])
                     + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            h_reg     <= INIT_H;
        end else begin
            state_reg <= state_next;
            h_reg     <= h_next;
        end
        round_reg <= round_next;
        v_reg     <= v_next;
        win_reg   <= win_next;
    end

endmodule

// ===== rtl/sha256_stream_hasher_unit.sv =====
// ============================================================================
// SHA-256 stream hasher
// Takes one message byte per request, pads and hashes, emits eight words.
// ============================================================================
// Each full block of 64 bytes is compressed by the core, one round per cycle;
// a message end adds one padding block, or two if the pad byte lands at slot 56 or later.
// Input: bytes are accepted only in the fill state; s_tready is low during compression.
// Digest: eight result words follow the last compression, one per cycle while m_tready is high.
// Reset clears the counters and reloads the initial hash values.
module sha256_stream_hasher_unit
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] msg_byte
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero pad
    output logic        m_tlast    // last_word
);

    localparam logic [2:0] ST_FILL  = 3'd0;
    localparam logic [2:0] ST_WAIT  = 3'd1;
    localparam logic [2:0] ST_PAD   = 3'd2;
    localparam logic [2:0] ST_PWAIT = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] total_reg, total_next;
    logic [23:0] acc_reg, acc_next;
    logic        fin_reg, fin_next;   // padding byte already placed
    logic        lenok_reg, lenok_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        ld_en, start, reinit, busy;
    logic [3:0]  ld_addr;
    logic [31:0] ld_data, hash_word;
    logic [63:0] bits;
    logic [7:0]  pbyte;

    sha256_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ld_en     (ld_en),
        .ld_addr   (ld_addr),
        .ld_data   (ld_data),
        .start     (start),
        .reinit    (reinit),
        .busy      (busy),
        .hash_sel  (oidx_reg),
        .hash_word (hash_word)
    );

    assign bits     = {total_reg, 3'b000};
    assign s_tready = (state_reg == ST_FILL);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {5'd0, oidx_reg, hash_word};
    assign m_tlast  = (oidx_reg == 3'd7);

    // Byte packing, padding and digest readout.
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        acc_next   = acc_reg;
        fin_next   = fin_reg;
        oidx_next  = oidx_reg;
        ld_en      = 1'b0;
        ld_addr    = fill_reg[5:2];
        ld_data    = '0;
        start      = 1'b0;
        reinit     = 1'b0;
        pbyte      = '0;
        unique case (state_reg)
            ST_FILL: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        acc_next   = {acc_reg[15:0], s_tdata};
                        total_next = total_reg + 61'd1;
                        fill_next  = fill_reg + 6'd1;
                        if (fill_reg[1:0] == 2'd3) begin
                            ld_en   = 1'b1;
                            ld_data = {acc_reg, s_tdata};
                        end
                        if (fill_reg == 6'd63) begin
                            start      = 1'b1;
                            state_next = ST_WAIT;
                        end else if (s_tlast) begin
                            state_next = ST_PAD;
                        end
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                    fin_next = 1'b0;
                    if (s_tlast && fill_reg == 6'd63 && s_tuser) begin
                        state_next = ST_PWAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (!busy && !start) begin
                    state_next = ST_FILL;
                end
            end
            ST_PAD: begin
                // One padding byte per cycle; the length only goes into the final block.
                if (!fin_reg) begin
                    pbyte    = PAD_BYTE;
                    fin_next = 1'b1;
                end else if (lenok_reg && fill_reg >= 6'(LEN_POS)) begin
                    pbyte = bits[6'(63 - 8 * (fill_reg - 6'(LEN_POS))) -: 8];
                end
                acc_next  = {acc_reg[15:0], pbyte};
                fill_next = fill_reg + 6'd1;
                if (fill_reg[1:0] == 2'd3) begin
                    ld_en   = 1'b1;
                    ld_data = {acc_reg, pbyte};
                end
                if (fill_reg == 6'd63) begin
                    start      = 1'b1;
                    state_next = ST_PWAIT;
                end
            end
            ST_PWAIT: begin
                if (!busy && !start) begin
                    // Read out when the length is in; else pad another block.
                    state_next = (fin_reg && lenok_reg) ? ST_OUT : ST_PAD;
                    oidx_next  = '0;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        reinit     = 1'b1;
                        total_next = '0;
                        fill_next  = '0;
                        state_next = ST_FILL;
                    end
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    // The length fits when the padding byte lands before slot 56, else in the next block.
    always_comb begin
        lenok_next = lenok_reg;
        if (state_reg == ST_FILL) begin
            lenok_next = 1'b0;
        end else if (state_reg == ST_PAD && !fin_reg) begin
            lenok_next = (fill_reg < 6'(LEN_POS));
        end else if (state_reg == ST_PWAIT && !busy && !start && fin_reg) begin
            lenok_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            fill_reg  <= '0;
            total_reg <= '0;
            fin_reg   <= 1'b0;
            oidx_reg  <= '0;
            lenok_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            fin_reg   <= fin_next;
            oidx_reg  <= oidx_next;
            lenok_reg <= lenok_next;
        end
        acc_reg <= acc_next;
    end

endmodule
